// File: rtl/core/dfs_path_finder_top_defines.svh
// Assertion macros for the path finder checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DFS_PATH_FINDER_TOP_DEFINES_SVH
`define DFS_PATH_FINDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dfs_pkg.sv
// Shared constants, types and a helper function for the path finder.
// No dependencies; the controller, datapath, top level and checker import this package.
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int GRP_W        = 8;
  localparam int GRP_N        = (MAX_VERTICES + GRP_W - 1) / GRP_W;
  localparam int PAD_W        = GRP_N * GRP_W;

  localparam logic [CNT_W-1:0] VC_RESET = CNT_W'(MAX_VERTICES);

  localparam logic [1:0] OP_ADD_EDGE  = 2'd0;
  localparam logic [1:0] OP_FIND_PATH = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  typedef enum logic [2:0] {
    ADJ_RD_A,
    ADJ_RD_B,
    ADJ_RD_CUR,
    ADJ_RD_NB,
    ADJ_RD_STK
  } adj_rd_sel_t;

  typedef enum logic [1:0] {
    STK_RD_DEPTH_M1,
    STK_RD_DEPTH_M2,
    STK_RD_IDX_M1
  } stk_rd_sel_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_END,
    EMIT_SINGLE,
    EMIT_MISS,
    EMIT_STACK
  } emit_t;

  typedef struct packed {
    logic        clear_rows;
    logic        adj_wr_a;
    logic        adj_wr_b;
    logic        query_init;
    logic        push;
    logic        mark_only;
    logic        pop;
    logic        load_top;
    logic        idx_load;
    logic        idx_dec;
    adj_rd_sel_t adj_rd_sel;
    stk_rd_sel_t stk_rd_sel;
    emit_t       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic same_ends;
    logic cand_empty;
    logic nb_is_end;
    logic depth_one;
    logic stack_full;
    logic idx_zero;
  } dp_status_t;

  // Lowest set bit, found group by group to keep the priority chains short.
  function automatic logic [VTX_W-1:0] lowest_bit(input logic [MAX_VERTICES-1:0] x);
    logic [PAD_W-1:0] xp;
    logic [GRP_W-1:0] grp_bits;
    int               grp;
    int               bit_pos;
    xp      = PAD_W'(x);
    grp     = 0;
    bit_pos = 0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (|xp[g*GRP_W +: GRP_W]) begin
        grp = g;
      end
    end
    grp_bits = xp[grp*GRP_W +: GRP_W];
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        bit_pos = i;
      end
    end
    return VTX_W'(grp * GRP_W + bit_pos);
  endfunction

endpackage

// File: rtl/core/dfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dfs_ctrl.sv
// Sequencer for edge updates, graph clears and the depth-first path search.
// Depends on dfs_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module dfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          operation,
  input  dfs_pkg::dp_status_t status,
  output dfs_pkg::dp_cmd_t    cmd,
  output logic                busy
);

  import dfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD_A,
    S_EDGE_WR_A,
    S_EDGE_RD_B,
    S_EDGE_WR_B,
    S_CHECK,
    S_SCAN,
    S_POP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.adj_rd_sel = ADJ_RD_CUR;
    cmd.stk_rd_sel = STK_RD_DEPTH_M1;
    cmd.emit       = EMIT_NONE;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_ADD_EDGE:  state_next = S_EDGE_RD_A;
            OP_FIND_PATH: state_next = S_CHECK;
            OP_CLEAR:     cmd.clear_rows = 1'b1;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD_A: begin
        cmd.adj_rd_sel = ADJ_RD_A;
        state_next     = S_EDGE_WR_A;
      end
      S_EDGE_WR_A: begin
        cmd.adj_wr_a = 1'b1;
        state_next   = S_EDGE_RD_B;
      end
      S_EDGE_RD_B: begin
        cmd.adj_rd_sel = ADJ_RD_B;
        state_next     = S_EDGE_WR_B;
      end
      S_EDGE_WR_B: begin
        cmd.adj_wr_b = 1'b1;
        state_next   = S_IDLE;
      end
      S_CHECK: begin
        priority if (!status.range_ok) begin
          cmd.emit   = EMIT_MISS;
          state_next = S_IDLE;
        end else if (status.same_ends) begin
          cmd.emit   = EMIT_SINGLE;
          state_next = S_IDLE;
        end else begin
          cmd.query_init = 1'b1;
          cmd.adj_rd_sel = ADJ_RD_A;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        // The row of the vertex on top of the stack is on the RAM output here.
        priority if (status.cand_empty && status.depth_one) begin
          cmd.emit   = EMIT_MISS;
          state_next = S_IDLE;
        end else if (status.cand_empty) begin
          cmd.pop        = 1'b1;
          cmd.stk_rd_sel = STK_RD_DEPTH_M2;
          state_next     = S_POP;
        end else if (status.nb_is_end) begin
          cmd.emit       = EMIT_END;
          cmd.idx_load   = 1'b1;
          cmd.stk_rd_sel = STK_RD_DEPTH_M1;
          state_next     = S_EMIT;
        end else if (!status.stack_full) begin
          cmd.push       = 1'b1;
          cmd.adj_rd_sel = ADJ_RD_NB;
        end else begin
          // Full stack: mark the neighbour and rescan the same top.
          cmd.mark_only  = 1'b1;
          cmd.adj_rd_sel = ADJ_RD_CUR;
        end
      end
      S_POP: begin
        cmd.load_top   = 1'b1;
        cmd.adj_rd_sel = ADJ_RD_STK;
        state_next     = S_SCAN;
      end
      S_EMIT: begin
        cmd.emit = EMIT_STACK;
        if (status.idx_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_dec    = 1'b1;
          cmd.stk_rd_sel = STK_RD_IDX_M1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/dfs_datapath.sv
// Adjacency and stack storage, visited marks, neighbour search and result register.
// Depends on dfs_pkg and dfs_ram; takes commands from dfs_ctrl.
`timescale 1ns / 1ps

module dfs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dfs_pkg::VTX_W-1:0]   vertex_a,
  input  logic [dfs_pkg::VTX_W-1:0]   vertex_b,
  input  logic                        cfg_we,
  input  logic [dfs_pkg::CNT_W-1:0]   cfg_data,
  input  dfs_pkg::dp_cmd_t            cmd,
  output dfs_pkg::dp_status_t         status,
  output logic                        result_valid,
  output logic [dfs_pkg::VTX_W-1:0]   path_vertex,
  output logic                        found,
  output logic                        last
);

  import dfs_pkg::*;

  logic [VTX_W-1:0]        a_q;
  logic [VTX_W-1:0]        b_q;
  logic [CNT_W-1:0]        vertex_count;
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    row_ok;
  logic [MAX_VERTICES-1:0] visited;
  logic [VTX_W-1:0]        cur;
  logic [CNT_W-1:0]        depth;
  logic [VTX_W-1:0]        idx;

  logic [CNT_W-1:0]        live_n;
  logic [MAX_VERTICES-1:0] live_mask;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [MAX_VERTICES-1:0] row_now;
  logic [MAX_VERTICES-1:0] cand;
  logic [VTX_W-1:0]        nb;
  logic                    adj_we;
  logic [VTX_W-1:0]        adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [VTX_W-1:0]        adj_raddr;
  logic                    stk_we;
  logic [VTX_W-1:0]        stk_waddr;
  logic [VTX_W-1:0]        stk_wdata;
  logic [VTX_W-1:0]        stk_raddr;
  logic [VTX_W-1:0]        stk_rdata;
  logic [CNT_W-1:0]        depth_m1;
  logic [CNT_W-1:0]        depth_m2;
  logic [VTX_W-1:0]        idx_m1;

  // A count above the vertex limit behaves as the limit.
  assign live_n = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (CNT_W'(i) < live_n);
    end
  end

  // Rows never written since the last clear read as empty.
  assign row_now = row_ok ? adj_rdata : '0;
  assign cand    = row_now & live_mask & ~visited;
  assign nb      = lowest_bit(cand);

  assign depth_m1 = depth - CNT_W'(1);
  assign depth_m2 = depth - CNT_W'(2);
  assign idx_m1   = idx - VTX_W'(1);

  assign adj_we    = cmd.adj_wr_a | cmd.adj_wr_b;
  assign adj_waddr = cmd.adj_wr_b ? b_q : a_q;
  assign adj_wdata = row_now | (cmd.adj_wr_b ? (MAX_VERTICES'(1) << a_q)
                                             : (MAX_VERTICES'(1) << b_q));

  always_comb begin
    unique case (cmd.adj_rd_sel)
      ADJ_RD_A:   adj_raddr = a_q;
      ADJ_RD_B:   adj_raddr = b_q;
      ADJ_RD_CUR: adj_raddr = cur;
      ADJ_RD_NB:  adj_raddr = nb;
      ADJ_RD_STK: adj_raddr = stk_rdata;
      default:    adj_raddr = cur;
    endcase
  end

  assign stk_we    = cmd.query_init | cmd.push;
  assign stk_waddr = cmd.query_init ? '0 : depth[VTX_W-1:0];
  assign stk_wdata = cmd.query_init ? a_q : nb;

  always_comb begin
    unique case (cmd.stk_rd_sel)
      STK_RD_DEPTH_M1: stk_raddr = depth_m1[VTX_W-1:0];
      STK_RD_DEPTH_M2: stk_raddr = depth_m2[VTX_W-1:0];
      STK_RD_IDX_M1:   stk_raddr = idx_m1;
      default:         stk_raddr = depth_m1[VTX_W-1:0];
    endcase
  end

  dfs_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfs_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign status.range_ok   = ({1'b0, a_q} < live_n) && ({1'b0, b_q} < live_n);
  assign status.same_ends  = (a_q == b_q);
  assign status.cand_empty = (cand == '0);
  assign status.nb_is_end  = (nb == b_q);
  assign status.depth_one  = (depth == CNT_W'(1));
  assign status.stack_full = (depth == CNT_W'(MAX_VERTICES));
  assign status.idx_zero   = (idx == '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      a_q <= vertex_a;
      b_q <= vertex_b;
    end
    row_ok <= row_valid[adj_raddr];
    if (cmd.load_top) begin
      cur <= stk_rdata;
    end else if (cmd.query_init) begin
      cur <= a_q;
    end else if (cmd.push) begin
      cur <= nb;
    end
    if (cmd.idx_load) begin
      idx <= depth_m1[VTX_W-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end
    unique case (cmd.emit)
      EMIT_END: begin
        path_vertex <= b_q;
        found       <= 1'b1;
        last        <= 1'b0;
      end
      EMIT_SINGLE: begin
        path_vertex <= a_q;
        found       <= 1'b1;
        last        <= 1'b1;
      end
      EMIT_MISS: begin
        path_vertex <= '0;
        found       <= 1'b0;
        last        <= 1'b1;
      end
      EMIT_STACK: begin
        path_vertex <= stk_rdata;
        found       <= 1'b1;
        last        <= status.idx_zero;
      end
      default: begin
        path_vertex <= path_vertex;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
      row_valid    <= '0;
      visited      <= '0;
      depth        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != EMIT_NONE);
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      if (cmd.clear_rows) begin
        row_valid <= '0;
      end else if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
      if (cmd.query_init) begin
        visited <= MAX_VERTICES'(1) << a_q;
        depth   <= CNT_W'(1);
      end else if (cmd.push) begin
        visited <= visited | (MAX_VERTICES'(1) << nb);
        depth   <= depth + CNT_W'(1);
      end else if (cmd.mark_only) begin
        visited <= visited | (MAX_VERTICES'(1) << nb);
      end else if (cmd.pop) begin
        depth <= depth_m1;
      end
    end
  end

endmodule

// File: rtl/core/dfs_path_finder_top.sv
// Sequence: add edge reads then writes row A, then row B; clear acts in idle; a query answered
// without a search (bad endpoint or start equal to end) gives its beat from the check state;
// a search scans, pushes and pops, after which a found path streams one beat a cycle.
// Throughput is one item at a time, set by the single-ported adjacency row read each step.
// Reset clears the 64 row valid bits, so the graph reads empty at once.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module dfs_path_finder_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation,
  input  logic [dfs_pkg::VTX_W-1:0] vertex_a,
  input  logic [dfs_pkg::VTX_W-1:0] vertex_b,
  output logic                      result_valid,
  output logic [dfs_pkg::VTX_W-1:0] path_vertex,
  output logic                      found,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dfs_pkg::CNT_W-1:0] cfg_data
);

  import dfs_pkg::*;

  logic       accept;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  dfs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .path_vertex  (path_vertex),
    .found        (found),
    .last         (last)
  );

endmodule

// File: rtl/core/dfs_path_finder_checker.sv
// Port-level checks on result framing and busy behaviour, bound to the top level.
// Depends on dfs_pkg and dfs_path_finder_top_defines.svh.
`timescale 1ns / 1ps
`include "dfs_path_finder_top_defines.svh"

module dfs_path_finder_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                operation,
  input logic                      result_valid,
  input logic [dfs_pkg::VTX_W-1:0] path_vertex,
  input logic                      found,
  input logic                      last
);

  import dfs_pkg::*;

  logic multi_cycle_item;

  assign multi_cycle_item = start && !busy &&
                            (operation == OP_ADD_EDGE || operation == OP_FIND_PATH);

  // A miss is a single beat carrying vertex zero.
  `DFS_ASSERT_SAME(a_miss_shape, result_valid && !found, last && (path_vertex == '0), "miss beat malformed")

  // A path streams without gaps until its final beat.
  `DFS_ASSERT_NEXT(a_path_runs_on, result_valid && !last, result_valid, "gap inside a path")

  // The next query cannot answer straight after a final beat.
  `DFS_ASSERT_NEXT(a_last_gap, result_valid && last, !result_valid, "beat right after final beat")

  `DFS_ASSERT_NEXT(a_work_busy, multi_cycle_item, busy, "multi-cycle item did not raise busy")

  `DFS_ASSERT_SAME(a_result_from_work, result_valid, $past(busy), "result without preceding work")

endmodule

bind dfs_path_finder_top dfs_path_finder_checker u_checker (.*);
